>>> rtl/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg
// Types and constants shared by the multi-slot heartbeat watchdog.
// ----------------------------------------------------------------------------
package msw_pkg;

    localparam int SLOTS        = 16;
    localparam int SLOT_W       = 8;
    localparam int UNITS_W      = 16;
    localparam int SCALE_W      = 8;
    localparam int CNT_W        = 16;
    localparam int LIM_W        = 24;
    localparam int IDX_W        = 4;
    localparam int PROD_W       = CNT_W + 5;
    localparam int CHECK_PERIOD = 30;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

    typedef enum logic [1:0] {
        ACT_KICK = 2'd0,
        ACT_REG  = 2'd1,
        ACT_FREE = 2'd2,
        ACT_TICK = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        COP_NONE,
        COP_KICK,
        COP_REG,
        COP_FREE
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COMMIT,
        ST_WALK,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [SLOT_W-1:0]   slot;
        logic [UNITS_W-1:0]  timeout_units;
    } t_in;

    typedef struct packed {
        logic             tripped;
        logic [IDX_W-1:0] trip_slot;
    } t_out;

    // Broadcast write command from the controller to every cell.
    typedef struct packed {
        t_cell_op          op;
        logic [SLOT_W-1:0] slot;
        logic [LIM_W-1:0]  limit;
    } t_cell_cmd;

endpackage

>>> rtl/multi_slot_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// multi_slot_heartbeat_watchdog
// Watchdog over a row of slot cells with a sticky trip flag.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_cmd and pulse start while busy is low; the
//   transaction is taken at that edge. busy stays high until the result is
//   out. Each transaction yields one result on o_result, marked by o_done for
//   exactly one cycle; the receiver cannot stall it.
//   Kick and unregister pass through EXEC and RESP; register also passes
//   through COMMIT. A check tick sends a token down the row of cells, one
//   slot per cycle, and the walk ends early if a slot trips partway.
//   After a trip, IDLE goes straight to RESP with the latched result.
//   Config: i_cfg_we writes i_cfg_wdata into check_scale; write only while
//   busy is low.
//   Reset (synchronous, active low) frees all slots, clears counters, limits
//   and the trip flag, and sets check_scale to 1. No clearing pass needed.
// ----------------------------------------------------------------------------
module multi_slot_heartbeat_watchdog
    import msw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  t_in                i_cmd,
    output logic               busy,
    output logic               o_done,
    output t_out               o_result,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata
);

    t_state              r_state;
    t_state              n_state;
    t_in                 r_item;
    logic [LIM_W-1:0]    r_lim;
    logic                r_trip;
    logic [IDX_W-1:0]    r_trip_idx;
    logic [SCALE_W-1:0]  r_scale;

    t_cell_cmd           cell_cmd;
    logic                tok_start;
    logic [SLOTS:0]      tok_chain;
    logic [SLOTS-1:0]    trip_vec;
    logic [IDX_W-1:0]    trip_idx;
    logic                walk_done;
    logic [LIM_W-1:0]    lim_mul;
    logic [LIM_W-1:0]    lim_floor;

    assign tok_chain[0] = tok_start;
    assign walk_done    = tok_chain[SLOTS];

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++) begin : g_cell
            msw_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (SLOT_W'(gi)),
                .i_cmd   (cell_cmd),
                .i_tok   (tok_chain[gi]),
                .o_tok   (tok_chain[gi+1]),
                .o_trip  (trip_vec[gi])
            );
        end
    endgenerate

    // at most one cell holds the token, so OR of indexes is the tripping slot
    always_comb begin
        trip_idx = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (trip_vec[i]) begin
                trip_idx = trip_idx | IDX_W'(i);
            end
        end
    end

    assign lim_mul   = LIM_W'(r_item.timeout_units) * LIM_W'(r_scale);
    assign lim_floor = LIM_W'(r_scale) * LIM_W'(CHECK_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        busy           = 1'b1;
        o_done         = 1'b0;
        tok_start      = 1'b0;
        cell_cmd.op    = COP_NONE;
        cell_cmd.slot  = r_item.slot;
        cell_cmd.limit = r_lim;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = r_trip ? ST_RESP : ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_item.action)
                    ACT_TICK: begin
                        tok_start = 1'b1;
                        n_state   = ST_WALK;
                    end
                    ACT_REG: begin
                        n_state = ST_COMMIT;
                    end
                    ACT_KICK: begin
                        cell_cmd.op = COP_KICK;
                        n_state     = ST_RESP;
                    end
                    default: begin
                        cell_cmd.op = COP_FREE;
                        n_state     = ST_RESP;
                    end
                endcase
            end
            ST_COMMIT: begin
                cell_cmd.op = COP_REG;
                n_state     = ST_RESP;
            end
            ST_WALK: begin
                if (walk_done || (trip_vec != '0)) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trip     <= 1'b0;
            r_trip_idx <= '0;
            r_scale    <= SCALE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if ((r_state == ST_WALK) && (trip_vec != '0)) begin
                r_trip     <= 1'b1;
                r_trip_idx <= trip_idx;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && start) begin
            r_item <= i_cmd;
        end
        if (r_state == ST_EXEC) begin
            r_lim <= (lim_mul < lim_floor) ? lim_floor : lim_mul;
        end
    end

    assign o_result.tripped   = r_trip;
    assign o_result.trip_slot = r_trip_idx;

    // ---- assertions ----
    a_one_trip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(trip_vec))
        else $error("more than one cell tripped");

    a_trip_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (trip_vec != '0) |-> (r_state == ST_WALK))
        else $error("trip outside of a tick walk");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trip |=> (r_trip && $stable(r_trip_idx)))
        else $error("trip flag or slot changed after trip");

    // an accepted transaction raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block not idle after result");

endmodule

>>> rtl/msw_cell.sv
// ----------------------------------------------------------------------------
// msw_cell
// One watchdog slot: used flag, heartbeat counter and limit. Checks its slot
// when the walk token arrives and passes the token on unless it trips.
// ----------------------------------------------------------------------------
module msw_cell
    import msw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_index,
    input  t_cell_cmd         i_cmd,
    input  logic              i_tok,
    output logic              o_tok,
    output logic              o_trip
);

    logic              r_used;
    logic [CNT_W-1:0]  r_count;
    logic [LIM_W-1:0]  r_limit;
    logic              r_tok;

    logic [PROD_W-1:0] prod;
    logic              over;
    logic              hit;

    // counter * 30 against limit
    assign prod   = PROD_W'(r_count) * PROD_W'(CHECK_PERIOD);
    assign over   = LIM_W'(prod) > r_limit;
    assign hit    = (i_cmd.slot == i_index);
    assign o_trip = r_tok & r_used & over;
    assign o_tok  = r_tok & ~(r_used & over);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_count <= '0;
            r_limit <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (r_tok && r_used && !over) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (hit) begin
                case (i_cmd.op)
                    COP_KICK: begin
                        r_count <= '0;
                    end
                    COP_REG: begin
                        r_used  <= 1'b1;
                        r_limit <= i_cmd.limit;
                    end
                    COP_FREE: begin
                        r_used  <= 1'b0;
                        r_count <= '0;
                        r_limit <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> verif/msw_checker.sv
// ----------------------------------------------------------------------------
// msw_checker
// Predicts and checks every result of the multi-slot heartbeat watchdog.
// Keeps its own copy of the slot table, trip latch and check_scale. Each
// accepted command updates that copy and queues the verdict it should give.
// Each o_done is checked against the oldest queued verdict, one field at a
// time.
// ----------------------------------------------------------------------------
module msw_checker
    import msw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  t_in                i_cmd,
    input  logic               i_done,
    input  t_out               i_result,
    input  logic               i_cfg_we,
    input  logic [SCALE_W-1:0] i_cfg_wdata,
    output int                 o_err_cnt,
    output int                 o_pend_cnt,
    output int                 o_res_cnt
);

    logic               wd_used   [SLOTS];
    logic [CNT_W-1:0]   wd_beats  [SLOTS];
    logic [LIM_W-1:0]   wd_limit  [SLOTS];
    logic               wd_tripped;
    logic [IDX_W-1:0]   wd_trip_idx;
    logic [SCALE_W-1:0] wd_scale;
    t_out               verdict_q [$];

    // Apply one command to the slot table and return the verdict it yields.
    function automatic t_out apply_cmd(input t_in cmd);
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] lim_floor;
        logic [IDX_W-1:0] idx;
        logic             walking;
        t_out             verdict;
        idx     = cmd.slot[IDX_W-1:0];
        walking = 1'b1;
        if (!wd_tripped) begin
            if (cmd.action == ACT_TICK) begin
                // walk stops at the first slot over its limit; later slots keep their count
                for (int s = 0; s < SLOTS; s++) begin
                    if (walking && wd_used[s]) begin
                        if (32'(wd_beats[s]) * CHECK_PERIOD > 32'(wd_limit[s])) begin
                            wd_tripped  = 1'b1;
                            wd_trip_idx = IDX_W'(s);
                            walking     = 1'b0;
                        end else begin
                            wd_beats[s] = wd_beats[s] + 1'b1;
                        end
                    end
                end
            end else if (cmd.slot < SLOTS) begin
                case (cmd.action)
                    ACT_KICK: begin
                        wd_beats[idx] = '0;
                    end
                    ACT_REG: begin
                        lim           = LIM_W'(cmd.timeout_units) * LIM_W'(wd_scale);
                        lim_floor     = LIM_W'(CHECK_PERIOD) * LIM_W'(wd_scale);
                        wd_used[idx]  = 1'b1;
                        wd_limit[idx] = (lim < lim_floor) ? lim_floor : lim;
                    end
                    ACT_FREE: begin
                        wd_used[idx]  = 1'b0;
                        wd_beats[idx] = '0;
                        wd_limit[idx] = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        verdict.tripped   = wd_tripped;
        verdict.trip_slot = wd_tripped ? wd_trip_idx : '0;
        return verdict;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_out want;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                wd_used[s]  = 1'b0;
                wd_beats[s] = '0;
                wd_limit[s] = '0;
            end
            wd_tripped  = 1'b0;
            wd_trip_idx = '0;
            wd_scale    = SCALE_RESET;
            verdict_q.delete();
            o_err_cnt = 0;
            o_res_cnt = 0;
        end else begin
            if (i_done) begin
                o_res_cnt++;
                if (verdict_q.size() == 0) begin
                    $display("%0t: result with none outstanding: tripped=%0b trip_slot=%0d",
                             $time, i_result.tripped, i_result.trip_slot);
                    o_err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_result.tripped !== want.tripped) begin
                        $display("%0t: tripped mismatch: expected %0b, got %0b",
                                 $time, want.tripped, i_result.tripped);
                        o_err_cnt++;
                    end
                    if (i_result.trip_slot !== want.trip_slot) begin
                        $display("%0t: trip_slot mismatch: expected %0d, got %0d",
                                 $time, want.trip_slot, i_result.trip_slot);
                        o_err_cnt++;
                    end
                end
            end
            if (i_start && !i_busy)
                verdict_q.push_back(apply_cmd(i_cmd));
            if (i_cfg_we)
                wd_scale = i_cfg_wdata;
        end
        o_pend_cnt = verdict_q.size();
    end

endmodule

>>> verif/tb_multi_slot_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// tb_multi_slot_heartbeat_watchdog
// Stimulus and verdict for the multi-slot heartbeat watchdog.
// A directed opening covers slots past the table, table edges, a kick on a
// free slot, re-registering a used slot and the count == limit boundary.
// Random phases follow at several check_scale settings. Ahead of each tick
// any slot about to expire is kicked, so the table stays alive and counts
// run up to their limits. A last phase sets check_scale to 0 and forces a
// trip in the middle of the walk, then checks that later commands are
// ignored. Checking is done by msw_checker.
// ----------------------------------------------------------------------------
module tb_multi_slot_heartbeat_watchdog;
    import msw_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 150;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    t_in                cmd       = '0;
    logic               cfg_we    = 1'b0;
    logic [SCALE_W-1:0] cfg_wdata = '0;
    logic               busy;
    logic               o_done;
    t_out               o_result;
    int                 err_cnt;
    int                 pend_cnt;
    int                 res_cnt;

    // Stimulus-side view of slot health, used only to kick slots due to expire.
    logic        hb_used  [SLOTS] = '{default: 1'b0};
    int unsigned hb_ticks [SLOTS] = '{default: 0};
    int unsigned hb_limit [SLOTS] = '{default: 0};
    int unsigned hb_scale         = 1;
    int          burst_left       = 0;
    int          n_items          = 0;
    int          n_act [4]        = '{default: 0};
    int          idle_cycles      = 0;

    multi_slot_heartbeat_watchdog i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .i_cmd       (cmd),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    msw_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_cmd       (cmd),
        .i_done      (o_done),
        .i_result    (o_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_err_cnt   (err_cnt),
        .o_pend_cnt  (pend_cnt),
        .o_res_cnt   (res_cnt)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Mostly back to back or short gaps, some long ones, and bursts with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if (r < 5) begin
            burst_left = $urandom_range(30, 10);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if ($urandom_range(9) == 0)
            return SLOT_W'($urandom);
        return SLOT_W'($urandom_range(SLOTS - 1));
    endfunction

    function automatic logic [UNITS_W-1:0] pick_units();
        int r;
        r = $urandom_range(99);
        if (r < 40) return UNITS_W'($urandom_range(900));
        if (r < 55) return UNITS_W'($urandom_range(60));
        if (r < 75) return UNITS_W'($urandom);
        if (r < 85) return '0;
        if (r < 95) return '1;
        return UNITS_W'(CHECK_PERIOD);
    endfunction

    // Present one command and return at the falling edge after it is taken.
    task automatic issue(input t_action act, input logic [SLOT_W-1:0] slot,
                         input logic [UNITS_W-1:0] units);
        int          gap;
        int unsigned u;
        t_in         c;
        gap = pick_gap();
        c.action        = act;
        c.slot          = slot;
        c.timeout_units = units;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        while (busy) @(negedge clk);
        @(negedge clk);
        n_items++;
        n_act[act]++;
        if (act == ACT_TICK) begin
            for (int s = 0; s < SLOTS; s++)
                if (hb_used[s]) hb_ticks[s]++;
        end else if (slot < SLOTS) begin
            case (act)
                ACT_KICK: hb_ticks[slot[IDX_W-1:0]] = 0;
                ACT_REG: begin
                    u = 32'(units);
                    hb_used[slot[IDX_W-1:0]]  = 1'b1;
                    hb_limit[slot[IDX_W-1:0]] = (u > CHECK_PERIOD ? u : CHECK_PERIOD) * hb_scale;
                end
                ACT_FREE: begin
                    hb_used[slot[IDX_W-1:0]]  = 1'b0;
                    hb_ticks[slot[IDX_W-1:0]] = 0;
                    hb_limit[slot[IDX_W-1:0]] = 0;
                end
                default: begin
                end
            endcase
        end
    endtask

    // Kick every slot the next tick would trip, then tick.
    task automatic safe_tick();
        for (int s = 0; s < SLOTS; s++)
            if (hb_used[s] && hb_ticks[s] * CHECK_PERIOD > hb_limit[s])
                issue(ACT_KICK, SLOT_W'(s), UNITS_W'($urandom));
        issue(ACT_TICK, SLOT_W'($urandom), UNITS_W'($urandom));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(negedge clk); while (pend_cnt != 0 || busy);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        hb_scale = 32'(value);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            safe_tick();
        else if (r < 55)
            issue(ACT_KICK, pick_slot(), UNITS_W'($urandom));
        else if (r < 80)
            issue(ACT_REG, pick_slot(), pick_units());
        else if (r < 90)
            issue(ACT_FREE, pick_slot(), UNITS_W'($urandom));
        else
            issue(t_action'($urandom_range(2)), SLOT_W'($urandom_range(255, SLOTS)),
                  UNITS_W'($urandom));
    endtask

    initial begin : stim
        int target;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening at the reset scale of 1
        safe_tick();
        issue(ACT_KICK, 8'd3, '1);
        issue(ACT_REG, 8'd0, '0);
        issue(ACT_REG, 8'd15, '1);
        issue(ACT_REG, 8'd16, 16'd100);
        issue(ACT_REG, 8'd255, '1);
        issue(ACT_KICK, 8'd200, '0);
        issue(ACT_FREE, 8'd255, '0);
        safe_tick();
        safe_tick();                     // slot 0 checked at count * 30 == limit
        issue(ACT_REG, 8'd0, 16'd29);    // rewrite limit, count kept
        safe_tick();
        issue(ACT_REG, 8'd8, 16'd61);
        repeat (3) safe_tick();
        issue(ACT_FREE, 8'd15, '0);
        issue(ACT_FREE, 8'd4, '0);
        issue(ACT_KICK, 8'd15, '0);
        issue(ACT_REG, 8'd12, 16'h5555);
        issue(ACT_REG, 8'd13, 16'hAAAA);
        issue(ACT_KICK, 8'h55, 16'hAAAA);
        issue(ACT_FREE, 8'hAA, 16'h5555);

        foreach (n_act[i]) begin
        end
        for (int p = 0; p < 5; p++) begin
            wait_idle();
            case (p)
                0: write_scale(8'd255);
                1: write_scale(SCALE_W'($urandom_range(254, 2)));
                2: write_scale(8'd1);
                3: write_scale(SCALE_W'($urandom_range(20, 2)));
                default: write_scale(8'd2);
            endcase
            repeat (PHASE_ITEMS) random_item();
        end

        // forced trip mid-walk with a zero scale
        wait_idle();
        issue(ACT_REG, 8'd0, '1);
        for (int s = 0; s < SLOTS; s++)
            if (hb_used[s]) issue(ACT_KICK, SLOT_W'(s), '0);
        target = $urandom_range(11, 4);
        wait_idle();
        write_scale('0);
        issue(ACT_REG, SLOT_W'(target), UNITS_W'($urandom));
        issue(ACT_TICK, SLOT_W'($urandom), UNITS_W'($urandom));
        issue(ACT_TICK, SLOT_W'($urandom), UNITS_W'($urandom));

        // after the trip every result stays the latched one, scale writes included
        repeat (12)
            issue(t_action'($urandom_range(3)), SLOT_W'($urandom), UNITS_W'($urandom));
        wait_idle();
        write_scale(8'd255);
        repeat (6)
            issue(t_action'($urandom_range(3)), SLOT_W'($urandom), UNITS_W'($urandom));

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pend_cnt != 0)
            $display("%0t: %0d results never arrived", $time, pend_cnt);
        $display("Sent %0d transactions: %0d kicks, %0d registers, %0d unregisters, %0d ticks",
                 n_items, n_act[ACT_KICK], n_act[ACT_REG], n_act[ACT_FREE], n_act[ACT_TICK]);
        $display("Scales 1, 255, mid values and 0; forced trip on slot %0d; %0d results checked",
                 target, res_cnt);
        if (err_cnt == 0 && pend_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
